// ===== src/gng_pkg.sv =====
// shared types and constants of the gaussian noise generator
`default_nettype none
package gng_pkg;

  localparam int unsigned SAMPLE_WIDTH     = 16;
  localparam int unsigned SAMPLE_FRAC_BITS = 12;
  localparam int unsigned RND_SHIFT        = 50 - SAMPLE_FRAC_BITS;

  localparam logic [14:0] MULT      = 15'd16807;
  localparam logic [30:0] MODULUS   = 31'h7FFF_FFFF;
  localparam logic [30:0] SEED_MASK = 31'd123459876;
  localparam logic [30:0] TWO_LN2   = 31'd1488522236;
  localparam logic [30:0] PI_Q29    = 31'd1686629713;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_UNIFORM = 2'd1;
  localparam logic [1:0] OP_GAUSS   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic KIND_UNIFORM = 1'b0;
  localparam logic KIND_GAUSS   = 1'b1;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [30:0] seed_value;
  } cmd_t;

  typedef struct packed {
    logic                    result_kind;
    logic [30:0]             uniform_value;
    logic [SAMPLE_WIDTH-1:0] gaussian_sample;
  } result_t;

endpackage
`default_nettype wire

// ===== src/gng_front.sv =====
// command queue: accepts input transactions and drops unused opcodes
`default_nettype none
module gng_front import gng_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [30:0] seed_value_i,
  output logic             full,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_pop_i
);

  cmd_t                 mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr_q, rptr_q;
  logic [CMDQ_AW:0]     cnt_q;
  logic                 wr, rd;

  assign full        = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rptr_q];

  // unused opcode is taken but never stored
  assign wr = push && !full && (opcode_i == OP_LOAD || opcode_i == OP_UNIFORM ||
                                opcode_i == OP_GAUSS);
  assign rd = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (!wr && rd) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= '{opcode: opcode_i, seed_value: seed_value_i};
  end

endmodule
`default_nettype wire

// ===== src/gng_outq.sv =====
// two-entry result queue
`default_nettype none
module gng_outq import gng_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_push_i,
  input  result_t      res_i,
  output logic         res_full_o,
  output logic         empty,
  input  wire logic    pop,
  output result_t      res_o
);

  result_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign res_o      = mem_q[rptr_q];
  assign wr         = res_push_i && !res_full_o;
  assign rd         = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      if (wr && !rd) cnt_q <= cnt_q + 2'd1;
      else if (!wr && rd) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= res_i;
  end

endmodule
`default_nettype wire

// ===== src/gng_back.sv =====
// sequencer: uniform source, fixed-point log, sin/cos on one multiplier; serial sqrt
`default_nettype none
module gng_back import gng_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_push_o,
  output result_t   res_o,
  input  wire logic res_full_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_UMUL, S_UFOLD, S_NORM, S_LSQ, S_LFOLD, S_LSUB, S_LMUL,
    S_SQINIT, S_SQRT, S_AMUL, S_QMUL, S_QSET, S_HMUL, S_DMUL, S_DFIX,
    S_SMUL, S_SSET, S_OCMUL, S_OCSET, S_OSMUL, S_OSSET
  } state_e;

  function automatic logic [6:0] div_const(input logic [2:0] k);
    logic [6:0] c;
    case (k)
      3'd0:    c = 7'd72;
      3'd1:    c = 7'd42;
      3'd2:    c = 7'd20;
      3'd3:    c = 7'd6;
      3'd4:    c = 7'd56;
      3'd5:    c = 7'd30;
      3'd6:    c = 7'd12;
      default: c = 7'd2;
    endcase
    return c;
  endfunction

  // floor(2^31 / divisor)
  function automatic logic [30:0] div_recip(input logic [2:0] k);
    logic [30:0] r;
    case (k)
      3'd0:    r = 31'd29826161;
      3'd1:    r = 31'd51130563;
      3'd2:    r = 31'd107374182;
      3'd3:    r = 31'd357913941;
      3'd4:    r = 31'd38347922;
      3'd5:    r = 31'd71582788;
      3'd6:    r = 31'd178956970;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] make_sample(input logic [63:0] p,
      input logic inf, input logic zero, input logic neg);
    logic [63:0]             r;
    logic [63:0]             maxp;
    logic [SAMPLE_WIDTH-1:0] smax, smin, y;
    r    = (p + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    maxp = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    smax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    smin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    if (zero) y = '0;
    else if (inf) y = neg ? smin : smax;
    else if (neg) y = (r > maxp + 64'd1) ? smin : SAMPLE_WIDTH'(~r + 64'd1);
    else y = (r > maxp) ? smax : r[SAMPLE_WIDTH-1:0];
    return y;
  endfunction

  state_e                  state_q, state_d;
  logic [30:0]             seed_q, seed_d;
  logic                    pend_q, pend_d;
  logic [SAMPLE_WIDTH-1:0] cache_q, cache_d;
  logic                    kind_q, kind_d;
  logic                    gsec_q, gsec_d;
  logic [30:0]             x1_q, x1_d, x2_q, x2_d;
  logic [30:0]             m_q, m_d;
  logic [4:0]              e_q, e_d, it_q, it_d;
  logic [23:0]             frac_q, frac_d;
  logic [29:0]             l_q, l_d;
  logic [45:0]             v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [30:0]             th_q, th_d, qv_q, qv_d, t_q, t_d, dv_q, dv_d;
  logic [30:0]             s_q, s_d, c_q, c_d;
  logic [2:0]              hs_q, hs_d;
  logic [SAMPLE_WIDTH-1:0] wc_q, wc_d;
  logic [63:0]             prod_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] usum;
  logic [30:0] ux;
  logic [31:0] mm;
  logic [45:0] rb;
  logic [2:0]  oct;
  logic [28:0] ang;
  logic [30:0] cm, sm, dsrc, dq;
  logic        cn, sn, inf;
  logic [37:0] dc, rem;
  logic [30:0] quo;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign usum = {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
  assign ux   = (usum >= {1'b0, MODULUS}) ? 31'(usum - {1'b0, MODULUS}) : usum[30:0];
  assign mm   = prod_q[61:30];
  assign rb   = r_q + bit_q;
  assign oct  = x2_q[30:28];
  assign ang  = oct[0] ? (29'd1 << 28) - {1'b0, x2_q[27:0]} : {1'b0, x2_q[27:0]};
  assign cm   = (oct[0] ^ oct[1]) ? s_q : c_q;
  assign sm   = (oct[0] ^ oct[1]) ? c_q : s_q;
  assign cn   = oct[2] ^ oct[1];
  assign sn   = oct[2];
  assign inf  = (x1_q == '0);
  assign dsrc = (hs_q == 3'd0 || hs_q == 3'd4) ? qv_q : prod_q[60:30];
  assign dq   = prod_q[61:31];
  assign dc   = 38'(dq) * 38'(div_const(hs_q));
  assign rem  = 38'(dv_q) - dc;
  assign quo  = (rem >= 38'(div_const(hs_q))) ? dq + 31'd1 : dq;

  always_comb begin
    state_d = state_q; seed_d = seed_q; pend_d = pend_q; cache_d = cache_q;
    kind_d = kind_q; gsec_d = gsec_q; x1_d = x1_q; x2_d = x2_q; m_d = m_q;
    e_d = e_q; it_d = it_q; frac_d = frac_q; l_d = l_q; v_d = v_q; r_d = r_q;
    bit_d = bit_q; th_d = th_q; qv_d = qv_q; t_d = t_q; dv_d = dv_q; s_d = s_q;
    c_d = c_q; hs_d = hs_q; wc_d = wc_q;
    mul_a = '0; mul_b = '0;
    cmd_pop_o = 1'b0; res_push_o = 1'b0;
    res_o = '{result_kind: KIND_UNIFORM, uniform_value: '0, gaussian_sample: '0};
    case (state_q)
      S_IDLE: begin
        // a command is taken only with room for its result
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.opcode)
            OP_LOAD: seed_d = cmd_i.seed_value;
            OP_UNIFORM: begin
              kind_d  = KIND_UNIFORM;
              state_d = S_UMUL;
            end
            OP_GAUSS: begin
              if (pend_q) begin
                res_push_o = 1'b1;
                res_o = '{result_kind: KIND_GAUSS, uniform_value: '0,
                          gaussian_sample: cache_q};
                pend_d = 1'b0;
              end else begin
                kind_d  = KIND_GAUSS;
                gsec_d  = 1'b0;
                state_d = S_UMUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_UMUL: begin
        mul_a   = {1'b0, seed_q ^ SEED_MASK};
        mul_b   = 32'(MULT);
        state_d = S_UFOLD;
      end
      S_UFOLD: begin
        seed_d = ux ^ SEED_MASK;
        if (kind_q == KIND_UNIFORM) begin
          res_push_o = 1'b1;
          res_o = '{result_kind: KIND_UNIFORM, uniform_value: ux, gaussian_sample: '0};
          state_d = S_IDLE;
        end else if (!gsec_q) begin
          x1_d    = ux;
          gsec_d  = 1'b1;
          state_d = S_UMUL;
        end else begin
          x2_d    = ux;
          m_d     = x1_q;
          e_d     = 5'd30;
          state_d = (x1_q == '0) ? S_AMUL : S_NORM;
        end
      end
      S_NORM: begin
        if (m_q[30]) begin
          it_d    = '0;
          frac_d  = '0;
          state_d = S_LSQ;
        end else begin
          m_d = {m_q[29:0], 1'b0};
          e_d = e_q - 5'd1;
        end
      end
      S_LSQ: begin
        mul_a   = {1'b0, m_q};
        mul_b   = {1'b0, m_q};
        state_d = S_LFOLD;
      end
      S_LFOLD: begin
        frac_d  = {frac_q[22:0], mm[31]};
        m_d     = mm[31] ? mm[31:1] : mm[30:0];
        it_d    = it_q + 5'd1;
        state_d = (it_q == 5'd23) ? S_LSUB : S_LSQ;
      end
      S_LSUB: begin
        l_d     = 30'(31 << 24) - (30'({e_q, 24'd0}) + 30'(frac_q));
        state_d = S_LMUL;
      end
      S_LMUL: begin
        mul_a   = 32'(l_q);
        mul_b   = 32'(TWO_LN2);
        state_d = S_SQINIT;
      end
      S_SQINIT: begin
        v_d     = {prod_q[59:30], 16'd0};
        r_d     = '0;
        bit_d   = 46'd1 << 44;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (v_q >= rb) begin
          v_d = v_q - rb;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = S_AMUL;
      end
      S_AMUL: begin
        mul_a   = 32'(ang);
        mul_b   = 32'(PI_Q29);
        state_d = S_QMUL;
      end
      S_QMUL: begin
        th_d    = prod_q[59:29];
        mul_a   = {1'b0, prod_q[59:29]};
        mul_b   = {1'b0, prod_q[59:29]};
        state_d = S_QSET;
      end
      S_QSET: begin
        qv_d    = prod_q[60:30];
        hs_d    = 3'd0;
        state_d = S_DMUL;
      end
      S_HMUL: begin
        mul_a   = {1'b0, qv_q};
        mul_b   = {1'b0, t_q};
        state_d = S_DMUL;
      end
      S_DMUL: begin
        dv_d    = dsrc;
        mul_a   = {1'b0, dsrc};
        mul_b   = {1'b0, div_recip(hs_q)};
        state_d = S_DFIX;
      end
      S_DFIX: begin
        t_d = ONE_Q30 - quo;
        if (hs_q == 3'd3) begin
          state_d = S_SMUL;
        end else if (hs_q == 3'd7) begin
          c_d     = ONE_Q30 - quo;
          state_d = S_OCMUL;
        end else begin
          hs_d    = hs_q + 3'd1;
          state_d = (hs_q == 3'd4) ? S_HMUL : S_HMUL;
        end
      end
      S_SMUL: begin
        mul_a   = {1'b0, th_q};
        mul_b   = {1'b0, t_q};
        state_d = S_SSET;
      end
      S_SSET: begin
        s_d     = prod_q[60:30];
        hs_d    = 3'd4;
        state_d = S_DMUL;
      end
      S_OCMUL: begin
        mul_a   = 32'(r_q[22:0]);
        mul_b   = {1'b0, cm};
        state_d = S_OCSET;
      end
      S_OCSET: begin
        wc_d    = make_sample(prod_q, inf, cm == '0, cn);
        state_d = S_OSMUL;
      end
      S_OSMUL: begin
        mul_a   = 32'(r_q[22:0]);
        mul_b   = {1'b0, sm};
        state_d = S_OSSET;
      end
      S_OSSET: begin
        cache_d    = make_sample(prod_q, inf, sm == '0, sn);
        pend_d     = 1'b1;
        res_push_o = 1'b1;
        res_o = '{result_kind: KIND_GAUSS, uniform_value: '0, gaussian_sample: wc_q};
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seed_q  <= 31'd1;
      pend_q  <= 1'b0;
      cache_q <= '0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      pend_q  <= pend_d;
      cache_q <= cache_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; gsec_q <= gsec_d; x1_q <= x1_d; x2_q <= x2_d; m_q <= m_d;
    e_q <= e_d; it_q <= it_d; frac_q <= frac_d; l_q <= l_d; v_q <= v_d; r_q <= r_d;
    bit_q <= bit_d; th_q <= th_d; qv_q <= qv_d; t_q <= t_d; dv_q <= dv_d;
    s_q <= s_d; c_q <= c_d; hs_q <= hs_d; wc_q <= wc_d;
    prod_q <= mul_p;
  end

endmodule
`default_nettype wire

// ===== src/gaussian_noise_generator.sv =====
// top level of the gaussian noise generator
// input channel: push / full, an input transaction is taken at a clock edge with push high
//   and full low; opcode_i selects load seed, uniform draw or gaussian draw
// result channel: empty / pop, the oldest result sits on the result ports while empty is
//   low and leaves at an edge with pop high; a load seed or unused opcode gives no result
// a four-entry command queue decouples the input side from the sequencer, and a
//   two-entry result queue decouples the sequencer from the receiver
// a gaussian draw that computes a new pair runs two seed steps, a normalize, 24 squaring
//   passes for the log and a bit-serial square root (these three skipped when the first
//   uniform is zero), then angle, sin/cos series and scaling, all sharing one 32 x 32
//   multiplier; the next gaussian draw returns the cached sample
// one command is executed at a time, so throughput is set by the sequencer
// reset: seed is 1, no sample cached, both queues empty
// when the receiver stalls, the result queue fills, the sequencer holds, and the
//   command queue fills until full rises
`default_nettype none
module gaussian_noise_generator import gng_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [30:0]             seed_value_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic                         result_kind_o,
  output logic [30:0]                  uniform_value_o,
  output logic signed [SAMPLE_WIDTH-1:0] gaussian_sample_o
);

  // command path between front and sequencer
  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  // result path between sequencer and result queue
  logic    res_push, res_full;
  result_t res_in, res_out;

  gng_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .opcode_i     (opcode_i),
    .seed_value_i (seed_value_i),
    .full         (full),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  gng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  gng_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign result_kind_o     = res_out.result_kind;
  assign uniform_value_o   = res_out.uniform_value;
  assign gaussian_sample_o = res_out.gaussian_sample;

endmodule
`default_nettype wire

// ===== tb/tb_gaussian_noise_generator.sv =====
// self-checking testbench of the gaussian noise generator
`timescale 1ns / 1ps
module tb_gaussian_noise_generator;
  import gng_pkg::*;

  // one row of the directed stimulus table
  typedef struct {
    logic [1:0]              opcode;
    logic [30:0]             seed_value;
    bit                      typed;
    logic                    kind;
    logic [30:0]             uniform_value;
    logic [SAMPLE_WIDTH-1:0] sample;
  } vector_t;

  typedef struct {
    logic                    kind;
    logic [30:0]             uniform_value;
    logic [SAMPLE_WIDTH-1:0] sample;
  } draw_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  logic [1:0]                     opcode_i = OP_LOAD;
  logic [30:0]                    seed_value_i = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic                           result_kind_o;
  logic [30:0]                    uniform_value_o;
  logic signed [SAMPLE_WIDTH-1:0] gaussian_sample_o;

  gaussian_noise_generator dut (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .seed_value_i,
    .empty, .pop, .result_kind_o, .uniform_value_o, .gaussian_sample_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted draws still owed by the block, oldest first
  draw_t       pending_draws[$];
  int unsigned error_count = 0;
  int unsigned draws_checked = 0;
  int unsigned gauss_checked = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  // predictor state: seed, cache flag and cached sample
  logic [30:0]             gen_seed;
  bit                      gen_cached;
  logic [SAMPLE_WIDTH-1:0] gen_cache_sample;

  task automatic report(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // one park-miller step: returns the product mod 2^31-1, advances the seed
  function automatic logic [30:0] park_miller_step();
    longint unsigned s, p;
    s = 64'(gen_seed ^ SEED_MASK);
    p = (s * 64'(MULT)) % 64'(MODULUS);
    gen_seed = 31'(p) ^ SEED_MASK;
    return 31'(p);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sqrt(-2 ln(x/2^31)) in q20, log by repeated squaring
  function automatic longint unsigned radius_of(input logic [30:0] x);
    int unsigned     e;
    longint unsigned m, frac, l, v;
    e = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (30 - e);
    frac = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    l = (64'd31 << 24) - ((64'(e) << 24) + frac);
    v = (l * 64'(TWO_LN2)) >> 30;
    return int_sqrt(v << 16);
  endfunction

  // scale, round half away and saturate one trig value
  function automatic logic [SAMPLE_WIDTH-1:0] scale_sample(input longint unsigned rad,
      input bit infinite, input longint unsigned mag, input bit neg);
    longint          maxp, r;
    maxp = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    if (mag == 0) return '0;
    if (infinite) return neg ? SAMPLE_WIDTH'(-maxp - 1) : SAMPLE_WIDTH'(maxp);
    r = longint'((rad * mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT);
    if (neg) return (r > maxp + 1) ? SAMPLE_WIDTH'(-maxp - 1) : SAMPLE_WIDTH'(-r);
    return (r > maxp) ? SAMPLE_WIDTH'(maxp) : SAMPLE_WIDTH'(r);
  endfunction

  task automatic box_muller(input logic [30:0] x1, input logic [30:0] x2,
      output logic [SAMPLE_WIDTH-1:0] cos_out, output logic [SAMPLE_WIDTH-1:0] sin_out);
    int unsigned     oct;
    longint unsigned f, a, th, q, t, s, c, rad, cm, sm;
    bit              cn, sn, inf;
    oct = x2 >> 28;
    f = 64'(x2) & ((64'd1 << 28) - 1);
    a = oct[0] ? ((64'd1 << 28) - f) : f;
    th = (a * 64'(PI_Q29)) >> 29;
    q = (th * th) >> 30;
    inf = (x1 == 0);
    rad = inf ? 0 : radius_of(x1);
    t = 64'(ONE_Q30) - q / 72;
    t = 64'(ONE_Q30) - ((q * t) >> 30) / 42;
    t = 64'(ONE_Q30) - ((q * t) >> 30) / 20;
    t = 64'(ONE_Q30) - ((q * t) >> 30) / 6;
    s = (th * t) >> 30;
    t = 64'(ONE_Q30) - q / 56;
    t = 64'(ONE_Q30) - ((q * t) >> 30) / 30;
    t = 64'(ONE_Q30) - ((q * t) >> 30) / 12;
    c = 64'(ONE_Q30) - ((q * t) >> 30) / 2;
    case (oct)
      0: begin cm = c; cn = 0; sm = s; sn = 0; end
      1: begin cm = s; cn = 0; sm = c; sn = 0; end
      2: begin cm = s; cn = 1; sm = c; sn = 0; end
      3: begin cm = c; cn = 1; sm = s; sn = 0; end
      4: begin cm = c; cn = 1; sm = s; sn = 1; end
      5: begin cm = s; cn = 1; sm = c; sn = 1; end
      6: begin cm = s; cn = 0; sm = c; sn = 1; end
      default: begin cm = c; cn = 0; sm = s; sn = 1; end
    endcase
    cos_out = scale_sample(rad, inf, cm, cn);
    sin_out = scale_sample(rad, inf, sm, sn);
  endtask

  // advances the predictor by one command; returns 1 when a draw is owed
  task automatic predict_draw(input logic [1:0] op, input logic [30:0] seed,
      output bit has_draw, output draw_t d);
    logic [30:0] x1, x2;
    d = '{KIND_UNIFORM, '0, '0};
    has_draw = 1'b0;
    case (op)
      OP_LOAD: gen_seed = seed;
      OP_UNIFORM: begin
        has_draw = 1'b1;
        d.uniform_value = park_miller_step();
      end
      OP_GAUSS: begin
        has_draw = 1'b1;
        d.kind = KIND_GAUSS;
        if (!gen_cached) begin
          x1 = park_miller_step();
          x2 = park_miller_step();
          box_muller(x1, x2, d.sample, gen_cache_sample);
          gen_cached = 1'b1;
        end else begin
          d.sample = gen_cache_sample;
          gen_cached = 1'b0;
        end
      end
      default: ;  // unused opcode is dropped by the block
    endcase
  endtask

  // offers one command and holds it until the block takes it
  task automatic send(input logic [1:0] op, input logic [30:0] seed,
      input bit typed, input draw_t typed_draw);
    bit    has_draw;
    draw_t d;
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    seed_value_i <= seed;
    do @(posedge clk_i); while (full);
    predict_draw(op, seed, has_draw, d);
    if (has_draw) pending_draws.push_back(typed ? typed_draw : d);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    // trailing seed loads may still sit in the command queue after the last result
    repeat (200) @(posedge clk_i);
  endtask

  // random command: mostly draws, some loads (a few of them stuck seeds), a few unused codes
  task automatic send_random();
    int unsigned pick;
    logic [1:0]  op;
    logic [30:0] seed;
    pick = $urandom_range(99);
    op = (pick < 8) ? OP_LOAD : (pick < 40) ? OP_UNIFORM : (pick < 95) ? OP_GAUSS : OP_UNUSED;
    seed = 31'($urandom);
    case ($urandom_range(49))
      0: seed = SEED_MASK;
      1: seed = SEED_MASK ^ MODULUS;
      2: seed = '0;
      3: seed = MODULUS;
      default: ;
    endcase
    send(op, seed, 1'b0, '{KIND_UNIFORM, '0, '0});
  endtask

  // receiver: random stalls plus a counted long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: each popped transaction against the oldest prediction
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_draws.size() == 0) begin
        report("unexpected result kind", result_kind_o, -1);
      end else begin
        want = pending_draws.pop_front();
        draws_checked++;
        if (want.kind == KIND_GAUSS) gauss_checked++;
        if (result_kind_o !== want.kind) report("result_kind", result_kind_o, want.kind);
        if (uniform_value_o !== want.uniform_value)
          report("uniform_value", uniform_value_o, want.uniform_value);
        if (gaussian_sample_o !== want.sample)
          report("gaussian_sample", gaussian_sample_o, $signed(want.sample));
      end
    end
  end

  vector_t directed[] = '{
    // first draws after reset
    '{OP_UNIFORM, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 0, KIND_GAUSS, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 0, KIND_GAUSS, 31'd0, 16'd0},
    // seed extremes
    '{OP_LOAD, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_LOAD, 31'h7FFF_FFFF, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    // unused opcode leaves no trace
    '{OP_UNUSED, 31'h7FFF_FFFF, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    // stuck seed: products are zero, then a zero first uniform saturates the cosine
    '{OP_LOAD, SEED_MASK, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 1, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 1, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 1, KIND_GAUSS, 31'd0, 16'h7FFF},
    '{OP_GAUSS, 31'd0, 1, KIND_GAUSS, 31'd0, 16'h0000},
    '{OP_LOAD, SEED_MASK ^ MODULUS, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 1, KIND_UNIFORM, 31'd0, 16'd0},
    // a seed load keeps the cached sample
    '{OP_LOAD, 31'd12345, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 0, KIND_GAUSS, 31'd0, 16'd0},
    '{OP_LOAD, 31'd999, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 0, KIND_GAUSS, 31'd0, 16'd0},
    '{OP_GAUSS, 31'd0, 0, KIND_GAUSS, 31'd0, 16'd0},
    '{OP_UNUSED, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0},
    '{OP_UNIFORM, 31'd0, 0, KIND_UNIFORM, 31'd0, 16'd0}
  };

  initial begin
    gen_seed = 31'd1;
    gen_cached = 1'b0;
    gen_cache_sample = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send(directed[i].opcode, directed[i].seed_value, directed[i].typed,
           '{directed[i].kind, directed[i].uniform_value, directed[i].sample});

    // long receiver hold-off while uniforms keep coming, so full must rise
    @(negedge clk_i);
    hold_left = 300;
    repeat (24) send(OP_UNIFORM, '0, 1'b0, '{KIND_UNIFORM, '0, '0});
    wait_drained();

    // idling phases: none, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 72 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 72 : (ph == 3) ? 32 : 0;
      repeat (350) send_random();
      wait_drained();
    end

    $display("checked %0d results (%0d gaussian) over directed and random commands",
             draws_checked, gauss_checked);
    $display("covered stuck seeds, cache across loads, unused opcodes and input back-pressure");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
